/* sv/pfla_pkg.sv */
// shared types, codes and constants of the page free list allocator
`default_nettype none

package pfla_pkg;

  // pages held in the link memory and width of a page number
  localparam int unsigned Pages = 4096;
  localparam int unsigned PageW = 12;
  // width of a configuration register
  localparam int unsigned CfgW = 13;

  // operation codes on the input stream
  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REBUILD = 2'd2
  } op_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_IN_USE  = 3'd2,
    ST_ALREADY = 3'd3,
    ST_BAD     = 3'd4
  } status_e;

  // register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_PAGE_COUNT = 2'd0,
    REG_BASE_LIMIT = 2'd1,
    REG_KERNEL_END = 2'd2
  } reg_e;

  // work kinds handed from the front to the back
  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_REBUILD = 2'd2,
    CMD_REPORT  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [CfgW-1:0] page_count;
    logic [CfgW-1:0] base_free_limit;
    logic [CfgW-1:0] kernel_end_page;
  } cfg_t;

  // classified command; status is only meaningful for a report
  typedef struct packed {
    cmd_e             kind;
    logic [PageW-1:0] page;
    status_e          status;
  } cmd_t;

  // one link memory word per page
  typedef struct packed {
    logic             on_list;
    logic             link_valid;
    logic [PageW-1:0] next;
  } entry_t;

  // page count clamped to the memory depth
  function automatic logic [CfgW-1:0] live_pages(cfg_t cfg);
    logic [CfgW-1:0] lim;
    lim = CfgW'(Pages);
    return (cfg.page_count < lim) ? cfg.page_count : lim;
  endfunction

endpackage

`default_nettype wire

/* sv/pfla_front.sv */
// front end: input transfer, command classification and a two-entry command queue
`default_nettype none

module pfla_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire pfla_pkg::cfg_t  cfg_i,
  input  wire logic            hold_i,
  input  wire logic            s_tvalid_i,
  output logic                 s_tready_o,
  // tdata: operation[1:0], page_index[13:2], page_referenced[14], zero[15]
  input  wire logic [15:0]     s_tdata_i,
  output logic                 q_valid_o,
  output pfla_pkg::cmd_t       q_cmd_o,
  input  wire logic            q_pop_i
);
  import pfla_pkg::*;

  op_e              op;
  logic [PageW-1:0] idx;
  logic             referenced;
  cmd_t             cmd;
  logic             push;

  cmd_t       item_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign op         = op_e'(s_tdata_i[1:0]);
  assign idx        = s_tdata_i[13:2];
  assign referenced = s_tdata_i[14];

  // classify: checks that need no list state are settled here
  always_comb begin
    cmd = '{kind: CMD_REPORT, page: idx, status: ST_OK};
    case (op)
      OP_ALLOC: begin
        cmd.kind = CMD_ALLOC;
      end
      OP_FREE: begin
        if ({1'b0, idx} >= live_pages(cfg_i)) begin
          cmd.status = ST_BAD;
        end else if (referenced) begin
          cmd.status = ST_IN_USE;
        end else begin
          cmd.kind = CMD_FREE;
        end
      end
      OP_REBUILD: begin
        cmd.kind = CMD_REBUILD;
      end
      default: begin
        cmd.kind = CMD_REPORT;
      end
    endcase
  end

  // queue control
  assign s_tready_o = (count_q != 2'd2) && !hold_i;
  assign push       = s_tvalid_i && s_tready_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign q_cmd_o    = item_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push    ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = q_pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      item_q[wr_ptr_q] <= cmd;
    end
  end

endmodule

`default_nettype wire

/* sv/pfla_back.sv */
// back end: list head, link memory, rebuild and clear sweep, result register
`default_nettype none

module pfla_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire pfla_pkg::cfg_t  cfg_i,
  input  wire logic            q_valid_i,
  input  wire pfla_pkg::cmd_t  q_cmd_i,
  output logic                 q_pop_o,
  output logic                 clearing_o,
  output logic                 m_tvalid_o,
  input  wire logic            m_tready_i,
  // tdata: status[2:0], granted_page[14:3], granted[15]
  output logic [15:0]          m_tdata_o
);
  import pfla_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_LOOK  = 3'b010,
    S_SWEEP = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [PageW-1:0] head_q, head_d;
  logic             head_valid_q, head_valid_d;
  cmd_t             cur_q, cur_d;
  logic [PageW-1:0] sweep_idx_q, sweep_idx_d;
  logic [PageW-1:0] succ_q, succ_d;
  logic             succ_valid_q, succ_valid_d;
  logic             clear_q, clear_d;
  logic             report_q, report_d;
  logic             m_tvalid_q, m_tvalid_d;
  logic [15:0]      m_tdata_q;

  entry_t           link_mem_q [Pages];
  entry_t           rd_entry_q;
  logic             rd_en;
  logic [PageW-1:0] rd_addr;
  logic             wr_en;
  logic [PageW-1:0] wr_addr;
  entry_t           wr_data;

  logic             out_free;
  logic             out_load;
  status_e          out_status;
  logic [PageW-1:0] out_page;
  logic             out_granted;
  logic [CfgW-1:0]  sweep_page;
  logic             sweep_free;

  assign out_free   = !m_tvalid_q || m_tready_i;
  assign q_pop_o    = (state_q == S_IDLE) && q_valid_i && out_free;
  assign clearing_o = (state_q == S_SWEEP) && clear_q;

  // free test for the page under the sweep
  assign sweep_page = {1'b0, sweep_idx_q};
  assign sweep_free = !clear_q && (sweep_page < live_pages(cfg_i)) &&
                      (((sweep_page > CfgW'(1)) && (sweep_page < cfg_i.base_free_limit)) ||
                       (sweep_page >= cfg_i.kernel_end_page));

  // sequencer
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    head_valid_d = head_valid_q;
    cur_d        = cur_q;
    sweep_idx_d  = sweep_idx_q;
    succ_d       = succ_q;
    succ_valid_d = succ_valid_q;
    clear_d      = clear_q;
    report_d     = report_q;
    rd_en        = 1'b0;
    rd_addr      = head_q;
    wr_en        = 1'b0;
    wr_addr      = head_q;
    wr_data      = '0;
    out_load     = 1'b0;
    out_status   = ST_OK;
    out_page     = '0;
    out_granted  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (q_pop_o) begin
          cur_d = q_cmd_i;
          case (q_cmd_i.kind)
            CMD_ALLOC: begin
              if (!head_valid_q) begin
                out_load   = 1'b1;
                out_status = ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                rd_addr = head_q;
                state_d = S_LOOK;
              end
            end
            CMD_FREE: begin
              rd_en   = 1'b1;
              rd_addr = q_cmd_i.page;
              state_d = S_LOOK;
            end
            CMD_REBUILD: begin
              sweep_idx_d  = PageW'(Pages - 1);
              succ_valid_d = 1'b0;
              clear_d      = 1'b0;
              report_d     = 1'b1;
              state_d      = S_SWEEP;
            end
            default: begin
              out_load   = 1'b1;
              out_status = q_cmd_i.status;
            end
          endcase
        end
      end
      S_LOOK: begin
        out_load = 1'b1;
        state_d  = S_IDLE;
        case (cur_q.kind)
          CMD_ALLOC: begin
            // pop the head and follow its link
            wr_en       = 1'b1;
            wr_addr     = head_q;
            wr_data     = '{on_list: 1'b0, link_valid: 1'b0, next: rd_entry_q.next};
            out_page    = head_q;
            out_granted = 1'b1;
            if (rd_entry_q.link_valid) begin
              head_d = rd_entry_q.next;
            end else begin
              head_d       = '0;
              head_valid_d = 1'b0;
            end
          end
          CMD_FREE: begin
            if (rd_entry_q.on_list) begin
              out_status = ST_ALREADY;
            end else begin
              // push the page onto the head
              wr_en        = 1'b1;
              wr_addr      = cur_q.page;
              wr_data      = '{on_list: 1'b1, link_valid: head_valid_q, next: head_q};
              head_d       = cur_q.page;
              head_valid_d = 1'b1;
            end
          end
          default: begin
            out_status = ST_OK;
          end
        endcase
      end
      S_SWEEP: begin
        // descending walk links each free page to the next free page above it
        wr_en   = 1'b1;
        wr_addr = sweep_idx_q;
        if (sweep_free) begin
          wr_data      = '{on_list: 1'b1, link_valid: succ_valid_q, next: succ_q};
          succ_d       = sweep_idx_q;
          succ_valid_d = 1'b1;
        end
        if (sweep_idx_q == '0) begin
          head_d       = sweep_free ? sweep_idx_q : (succ_valid_q ? succ_q : '0);
          head_valid_d = sweep_free || succ_valid_q;
          out_load     = report_q;
          report_d     = 1'b0;
          clear_d      = 1'b0;
          state_d      = S_IDLE;
        end else begin
          sweep_idx_d = sweep_idx_q - PageW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // result register
  always_comb begin
    m_tvalid_d = m_tvalid_q;
    if (out_load) begin
      m_tvalid_d = 1'b1;
    end else if (m_tready_i) begin
      m_tvalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_SWEEP;
      head_q       <= '0;
      head_valid_q <= 1'b0;
      sweep_idx_q  <= PageW'(Pages - 1);
      succ_valid_q <= 1'b0;
      clear_q      <= 1'b1;
      report_q     <= 1'b0;
      m_tvalid_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      head_valid_q <= head_valid_d;
      sweep_idx_q  <= sweep_idx_d;
      succ_valid_q <= succ_valid_d;
      clear_q      <= clear_d;
      report_q     <= report_d;
      m_tvalid_q   <= m_tvalid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    succ_q <= succ_d;
    if (out_load) begin
      m_tdata_q <= {out_granted, out_page, out_status};
    end
  end

  // link memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      link_mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_entry_q <= link_mem_q[rd_addr];
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;

endmodule

`default_nettype wire

/* sv/page_free_list_allocator.sv */
// top level of the page free list allocator: configuration registers and block wiring
`default_nettype none

// Physical page allocator kept as a last-in first-out free list in a 4096-entry
// link memory. Each input transfer yields exactly one result transfer. A free
// rejected in classification, an allocate on an empty list and the unused code
// are answered from the idle state; allocate and free go through a link memory
// read followed by the write and head update. Rebuild writes every link memory
// entry once, top page first. After reset a clearing pass writes every entry
// while no input transfer is accepted; configuration writes are taken throughout.
// A two-entry command queue separates input classification from the list work;
// it takes inputs until full while a result waits on the output register.
module page_free_list_allocator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // command stream
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  // tdata: operation[1:0], page_index[13:2], page_referenced[14], zero[15]
  input  wire logic [15:0] s_tdata_i,
  // result stream
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  // tdata: status[2:0], granted_page[14:3], granted[15]
  output logic [15:0]      m_tdata_o
);
  import pfla_pkg::*;

  cfg_t cfg_q, cfg_d;
  reg_e reg_sel;
  logic cfg_wr;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;
  logic clearing;

  // register access
  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_sel)
        REG_PAGE_COUNT: cfg_d.page_count      = pwdata[CfgW-1:0];
        REG_BASE_LIMIT: cfg_d.base_free_limit = pwdata[CfgW-1:0];
        REG_KERNEL_END: cfg_d.kernel_end_page = pwdata[CfgW-1:0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_PAGE_COUNT: prdata = {{(32-CfgW){1'b0}}, cfg_q.page_count};
      REG_BASE_LIMIT: prdata = {{(32-CfgW){1'b0}}, cfg_q.base_free_limit};
      REG_KERNEL_END: prdata = {{(32-CfgW){1'b0}}, cfg_q.kernel_end_page};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.page_count      <= '0;
      cfg_q.base_free_limit <= '0;
      cfg_q.kernel_end_page <= CfgW'(4096);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // classification and command queue
  pfla_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .hold_i     (clearing),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .q_valid_o  (q_valid),
    .q_cmd_o    (q_cmd),
    .q_pop_i    (q_pop)
  );

  // list engine
  pfla_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_valid_i  (q_valid),
    .q_cmd_i    (q_cmd),
    .q_pop_o    (q_pop),
    .clearing_o (clearing),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

`ifndef SYNTHESIS
  // a granted page always comes with an ok status
  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tdata_o[15] |-> m_tdata_o[2:0] == ST_OK)
    else $error("granted result without ok status");

  // any failure carries no page
  a_fail_no_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (m_tdata_o[2:0] != ST_OK) |-> !m_tdata_o[15] && (m_tdata_o[14:3] == '0))
    else $error("failed result carries a page");

  // no command transfer while the memory is being cleared
  a_clear_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !s_tready_o)
    else $error("input taken during clearing pass");

  // the queue is only popped when it holds a command
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty command queue");
`endif

endmodule

`default_nettype wire

/* dv/page_free_list_allocator_test.sv */
// self-checking testbench for the page free list allocator
module page_free_list_allocator_test;
  import pfla_pkg::*;

  // the fourth operation code is unused and must be ignored
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HoldCycles = 400;
  localparam int DrainLimit = 20000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_e;

  typedef struct packed {
    status_e          status;
    logic [PageW-1:0] page;
    logic             granted;
  } page_reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  // tdata: operation[1:0], page_index[13:2], page_referenced[14], zero[15]
  logic [15:0] s_tdata_i = '0;
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  // tdata: status[2:0], granted_page[14:3], granted[15]
  logic [15:0] m_tdata_o;

  page_free_list_allocator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predicted allocator state and register copies
  logic [CfgW-1:0]  cfg_pages = '0;
  logic [CfgW-1:0]  cfg_base = '0;
  logic [CfgW-1:0]  cfg_kend = CfgW'(4096);
  logic [PageW-1:0] head_page = '0;
  logic             head_ok = 1'b0;
  bit [PageW-1:0]   link_mem [Pages];
  bit               linked [Pages];
  bit               listed [Pages];

  page_reply_t      pending_replies [$];
  logic [PageW-1:0] held_pages [$];
  idle_e            idle_mode = IDLE_NONE;
  int               reply_errors = 0;
  int               replies_seen = 0;
  int               commands_sent = 0;
  int               rebuilds_sent = 0;
  int               settings_used = 0;
  bit               hold_armed = 1'b0;
  bit               hold_taken = 1'b0;
  int               hold_left = 0;

  // expected reply for one command, updating the predicted list
  function automatic page_reply_t apply_page_op(logic [1:0] op, logic [PageW-1:0] idx,
                                                logic pinned);
    page_reply_t      reply;
    logic [CfgW-1:0]  live;
    logic [PageW-1:0] tail;
    bit               have_tail;
    reply = '{status: ST_OK, page: '0, granted: 1'b0};
    live = (cfg_pages < CfgW'(Pages)) ? cfg_pages : CfgW'(Pages);
    tail = '0;
    have_tail = 1'b0;
    case (op)
      OP_ALLOC: begin
        if (!head_ok) begin
          reply.status = ST_EMPTY;
        end else begin
          reply.page = head_page;
          reply.granted = 1'b1;
          // popping the tail leaves the list empty
          if (linked[head_page]) begin
            linked[reply.page] = 1'b0;
            head_page = link_mem[reply.page];
          end else begin
            head_page = '0;
            head_ok = 1'b0;
          end
          listed[reply.page] = 1'b0;
        end
      end
      OP_FREE: begin
        // index first, then references, then double free
        if (CfgW'(idx) >= live) begin
          reply.status = ST_BAD;
        end else if (pinned) begin
          reply.status = ST_IN_USE;
        end else if (listed[idx]) begin
          reply.status = ST_ALREADY;
        end else begin
          link_mem[idx] = head_page;
          linked[idx] = head_ok;
          listed[idx] = 1'b1;
          head_page = idx;
          head_ok = 1'b1;
        end
      end
      OP_REBUILD: begin
        head_page = '0;
        head_ok = 1'b0;
        for (int i = 0; i < Pages; i++) begin
          linked[i] = 1'b0;
          listed[i] = 1'b0;
        end
        // chain free pages in ascending order
        for (int i = 0; i < Pages; i++) begin
          if (i < live && ((i > 1 && i < cfg_base) || i >= cfg_kend)) begin
            listed[i] = 1'b1;
            if (have_tail) begin
              link_mem[tail] = PageW'(i);
              linked[tail] = 1'b1;
            end else begin
              head_page = PageW'(i);
              head_ok = 1'b1;
            end
            tail = PageW'(i);
            have_tail = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    return reply;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (reply_errors < 40) begin
      $display("mismatch on reply %0d: %s got %0d expected %0d", replies_seen, what, got,
               want);
    end
    reply_errors++;
  endtask

  // output side: random stalls, plus one long hold-off when armed
  always @(posedge clk_i) begin
    if (hold_armed && !hold_taken) begin
      hold_left = HoldCycles;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready_i <= 1'b0;
    end else if (idle_mode == IDLE_RECEIVER) begin
      m_tready_i <= ($urandom_range(0, 99) >= 83);
    end else if (idle_mode == IDLE_BOTH) begin
      m_tready_i <= ($urandom_range(0, 99) >= 26);
    end else begin
      m_tready_i <= 1'b1;
    end
  end

  // compare each reply transfer with the oldest prediction
  always @(posedge clk_i) begin
    page_reply_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      replies_seen++;
      if (pending_replies.size() == 0) begin
        report_mismatch("reply with nothing pending, tdata", m_tdata_o, 0);
      end else begin
        want = pending_replies.pop_front();
        if (m_tdata_o[2:0] != want.status)
          report_mismatch("status", m_tdata_o[2:0], want.status);
        if (m_tdata_o[14:3] != want.page)
          report_mismatch("granted_page", m_tdata_o[14:3], want.page);
        if (m_tdata_o[15] != want.granted)
          report_mismatch("granted", m_tdata_o[15], want.granted);
      end
    end
  end

  // one command transfer, with a random gap before it when the sender idles
  task automatic send_item(logic [1:0] op, logic [PageW-1:0] idx, logic pinned);
    int          pct;
    page_reply_t reply;
    pct = (idle_mode == IDLE_SENDER) ? 83 : (idle_mode == IDLE_BOTH) ? 26 : 0;
    while ($urandom_range(0, 99) < pct) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i <= {1'b0, pinned, idx, op};
    do @(posedge clk_i); while (!s_tready_o);
    reply = apply_page_op(op, idx, pinned);
    pending_replies.push_back(reply);
    if (reply.granted) held_pages.push_back(reply.page);
    if (op == OP_REBUILD) begin
      held_pages.delete();
      rebuilds_sent++;
    end
    commands_sent++;
  endtask

  // mostly allocate and free of pages handed out earlier, some noise
  task automatic send_random_item();
    logic [1:0]       op;
    logic [PageW-1:0] idx;
    logic             pinned;
    int               r;
    int               k;
    int               span;
    span = (cfg_pages + 4 > 4095) ? 4095 : cfg_pages + 4;
    r = $urandom_range(0, 99);
    idx = PageW'($urandom_range(0, 4095));
    pinned = 1'($urandom_range(0, 1));
    if (r < 2) begin
      op = OP_REBUILD;
    end else if (r < 5) begin
      op = OP_UNUSED;
    end else if (r < 50) begin
      op = OP_ALLOC;
    end else begin
      op = OP_FREE;
      pinned = ($urandom_range(0, 7) == 0);
      if (held_pages.size() > 0 && $urandom_range(0, 99) < 70) begin
        k = $urandom_range(0, held_pages.size() - 1);
        idx = held_pages[k];
        held_pages.delete(k);
      end else if ($urandom_range(0, 3) != 0) begin
        idx = PageW'($urandom_range(0, span));
      end
    end
    send_item(op, idx, pinned);
  endtask

  // stop sending and wait for every predicted reply
  task automatic wait_for_replies();
    s_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_replies.size() != 0);
  endtask

  task automatic write_reg(reg_e idx, int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_PAGE_COUNT: cfg_pages = CfgW'(value);
      REG_BASE_LIMIT: cfg_base = CfgW'(value);
      REG_KERNEL_END: cfg_kend = CfgW'(value);
      default: begin
      end
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // registers change only with the block idle
  task automatic configure(int unsigned pages, int unsigned base, int unsigned kend);
    wait_for_replies();
    repeat (4) @(posedge clk_i);
    write_reg(REG_PAGE_COUNT, pages);
    write_reg(REG_BASE_LIMIT, base);
    write_reg(REG_KERNEL_END, kend);
    settings_used++;
  endtask

  // reset values: no pages managed, list empty
  task automatic test_reset_state();
    idle_mode = IDLE_NONE;
    send_item(OP_ALLOC, '0, 1'b0);
    send_item(OP_FREE, '0, 1'b0);
    send_item(OP_FREE, '1, 1'b1);
    send_item(OP_REBUILD, '0, 1'b0);
  endtask

  // small map: error codes, tail handling, unused code, page zero
  task automatic test_small_map();
    configure(32, 6, 28);
    idle_mode = IDLE_NONE;
    send_item(OP_REBUILD, '0, 1'b0);
    send_item(OP_ALLOC, '0, 1'b0);
    send_item(OP_ALLOC, '0, 1'b0);
    send_item(OP_FREE, 12'd3, 1'b1);
    send_item(OP_FREE, 12'd4, 1'b0);
    send_item(OP_FREE, 12'd32, 1'b0);
    send_item(OP_FREE, 12'd4095, 1'b0);
    send_item(OP_FREE, 12'd3, 1'b0);
    send_item(OP_ALLOC, '0, 1'b0);
    send_item(OP_UNUSED, 12'hfff, 1'b1);
    send_item(OP_FREE, 12'd0, 1'b0);
    // drain the list to empty
    repeat (8) send_item(OP_ALLOC, 12'd1, 1'b0);
    send_item(OP_FREE, 12'd7, 1'b0);
    send_item(OP_ALLOC, '0, 1'b0);
    send_item(OP_ALLOC, '0, 1'b0);
  endtask

  // output held off while commands keep coming, so the input stalls
  task automatic test_backpressure();
    idle_mode = IDLE_NONE;
    hold_armed = 1'b1;
    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
    repeat (40) send_random_item();
  endtask

  // sender pauses until every reply is back, then resumes
  task automatic test_drain_pause();
    idle_mode = IDLE_BOTH;
    repeat (20) send_random_item();
    wait_for_replies();
    repeat (20) send_random_item();
  endtask

  task automatic test_random_phase(int unsigned pages, int unsigned base, int unsigned kend,
                                   idle_e mode, int count);
    configure(pages, base, kend);
    idle_mode = mode;
    send_item(OP_REBUILD, '0, 1'b0);
    repeat (count) send_random_item();
  endtask

  initial begin
    int guard;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_small_map();
    test_backpressure();
    test_drain_pause();
    test_random_phase(4096, 4096, 4096, IDLE_NONE, 230);
    test_random_phase(64, 10, 40, IDLE_SENDER, 230);
    test_random_phase(16, 0, 0, IDLE_RECEIVER, 230);
    test_random_phase(4096, 0, 4096, IDLE_BOTH, 230);
    test_random_phase(200, 130, 150, IDLE_RECEIVER, 230);
    test_random_phase(0, 4096, 0, IDLE_SENDER, 200);

    // let the last replies come out, then a short quiet window
    s_tvalid_i <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk_i);
      guard++;
    end while (pending_replies.size() != 0 && guard < DrainLimit);
    if (pending_replies.size() != 0)
      report_mismatch("replies never delivered, count", 0, pending_replies.size());
    repeat (16) @(posedge clk_i);

    $display("covered %0d commands (%0d rebuilds), %0d replies checked", commands_sent,
             rebuilds_sent, replies_seen);
    $display("over %0d map settings, four idle patterns and a long output hold-off",
             settings_used);
    if (reply_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // run limit
  initial begin
    #(36_000_000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
